// File: src/sssp_pkg.sv
// Package for the single-source shortest path engine.
// Holds the transfer payload types, the register indexes and the controller interface.
// No dependencies.
`timescale 1ns / 1ps

package sssp_pkg;

  localparam int VERTEX_W = 5;
  localparam int COUNT_W  = 6;
  localparam int WEIGHT_W = 16;
  localparam int DIST_W   = 32;
  localparam int CFG_W    = 6;
  localparam int CFG_IDX_W = 1;
  localparam int RESULT_LIMIT = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_VERTEX = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT  = 1'd1;

  typedef struct packed {
    logic [VERTEX_W-1:0]        edge_from;
    logic [VERTEX_W-1:0]        edge_to;
    logic signed [WEIGHT_W-1:0] edge_weight;
    logic                       last_edge;
  } in_t;

  typedef struct packed {
    logic [VERTEX_W-1:0]      vertex_id;
    logic                     reachable;
    logic signed [DIST_W-1:0] distance;
    logic                     negative_cycle;
    logic                     last_vertex;
  } out_t;

  typedef struct packed {
    logic [VERTEX_W-1:0]        from_v;
    logic [VERTEX_W-1:0]        to_v;
    logic signed [WEIGHT_W-1:0] weight;
  } edge_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_en;   // edges may be taken from the input channel
    logic init;      // start of a run: clear marks, seed the source
    logic fetch;     // read the current edge
    logic dread;     // read both end-point distances
    logic relax;     // evaluate the edge and update
    logic pass_end;  // close a pass
    logic out_rd;    // read the distance of the current result vertex
    logic out_load;  // move a result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start;       // last edge transferred this cycle
    logic src_ok;      // source lies among the vertices in use
    logic edges_empty; // no stored edges
    logic edge_last;   // current edge is the final stored one
    logic checking;    // the pass in progress is the cycle check
    logic out_free;    // output register can take a result
    logic out_last;    // current result vertex is the final one
  } sts_t;

endpackage

// File: src/sssp_ctrl.sv
// Controller state machine of the shortest path engine.
// Depends on sssp_pkg for the command and status structs.
`timescale 1ns / 1ps

module sssp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  sssp_pkg::sts_t  sts,
  output sssp_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_DREAD = 3'd3;
  localparam logic [2:0] S_RELAX = 3'd4;
  localparam logic [2:0] S_PEND  = 3'd5;
  localparam logic [2:0] S_ORD   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.load_en = 1'b1;
        if (sts.start) begin
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init = 1'b1;
        if (!sts.src_ok) begin
          state_next = S_ORD;
        end else if (sts.edges_empty) begin
          state_next = S_PEND;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_DREAD;
      end
      S_DREAD: begin
        cmd.dread  = 1'b1;
        state_next = S_RELAX;
      end
      S_RELAX: begin
        cmd.relax  = 1'b1;
        state_next = sts.edge_last ? S_PEND : S_FETCH;
      end
      S_PEND: begin
        cmd.pass_end = 1'b1;
        if (sts.checking) begin
          state_next = S_ORD;
        end else if (sts.edges_empty) begin
          state_next = S_PEND;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_ORD: begin
        cmd.out_rd = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = sts.out_last ? S_IDLE : S_ORD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: src/sssp_dp.sv
// Datapath of the shortest path engine: edge memory, distance memory, reached marks,
// relaxation adder and comparator, counters, configuration and output registers.
// Depends on sssp_pkg.
`timescale 1ns / 1ps

module sssp_dp #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_EDGES    = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  sssp_pkg::cmd_t                     cmd,
  output sssp_pkg::sts_t                     sts,
  input  logic                               in_valid,
  input  sssp_pkg::in_t                      in_data,
  input  logic                               out_stall,
  output logic                               out_valid,
  output sssp_pkg::out_t                     out_data,
  input  logic                               cfg_we,
  input  logic [sssp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sssp_pkg::CFG_W-1:0]         cfg_data
);

  localparam int NV_LIMIT = (MAX_VERTICES < sssp_pkg::RESULT_LIMIT) ?
                            MAX_VERTICES : sssp_pkg::RESULT_LIMIT;
  localparam int VW = $clog2(NV_LIMIT);
  localparam int EW = $clog2(MAX_EDGES + 1);
  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam logic [sssp_pkg::COUNT_W-1:0] NV_MAX = sssp_pkg::COUNT_W'(NV_LIMIT);
  localparam logic [EW-1:0] EDGE_CAP = EW'(MAX_EDGES);

  logic [sssp_pkg::VERTEX_W-1:0] source_vertex;
  logic [sssp_pkg::COUNT_W-1:0]  vertex_count;
  logic [sssp_pkg::COUNT_W-1:0]  nv;

  sssp_pkg::edge_t edge_mem [MAX_EDGES];
  sssp_pkg::edge_t edge_q;
  logic [EW-1:0]   edge_total;
  logic [EW-1:0]   edge_idx;

  logic [sssp_pkg::DIST_W-1:0] dist_mem [NV_LIMIT];
  logic [sssp_pkg::DIST_W-1:0] dist_a;
  logic [sssp_pkg::DIST_W-1:0] dist_b;
  logic [VW-1:0]               addr_a;
  logic [NV_LIMIT-1:0]         reached;

  logic [sssp_pkg::COUNT_W-1:0] pass_cnt;
  logic [sssp_pkg::COUNT_W-1:0] out_idx;
  logic                         changed;
  logic                         checking;
  logic                         neg;

  logic                         in_acc;
  logic                         src_ok;
  logic [VW-1:0]                u_idx;
  logic [VW-1:0]                v_idx;
  logic [VW-1:0]                o_idx;
  logic                         edge_ok;
  logic signed [sssp_pkg::DIST_W:0]   sum;
  logic signed [sssp_pkg::DIST_W-1:0] cand;
  logic                         improve;

  assign in_acc = cmd.load_en && in_valid;

  // Effective vertex count: zero counts as one, large values saturate.
  always_comb begin
    priority if (vertex_count == '0) begin
      nv = sssp_pkg::COUNT_W'(1);
    end else if (vertex_count > NV_MAX) begin
      nv = NV_MAX;
    end else begin
      nv = vertex_count;
    end
  end

  assign src_ok = {1'b0, source_vertex} < nv;
  assign u_idx  = edge_q.from_v[VW-1:0];
  assign v_idx  = edge_q.to_v[VW-1:0];
  assign o_idx  = out_idx[VW-1:0];
  assign addr_a = cmd.out_rd ? o_idx : u_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_vertex <= '0;
      vertex_count  <= sssp_pkg::COUNT_W'(32);
    end else if (cfg_we) begin
      unique case (cfg_index)
        sssp_pkg::REG_SOURCE_VERTEX: source_vertex <= cfg_data[sssp_pkg::VERTEX_W-1:0];
        sssp_pkg::REG_VERTEX_COUNT:  vertex_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Edge memory: written while loading, read one edge per fetch.
  always_ff @(posedge clk) begin
    if (in_acc && (edge_total < EDGE_CAP)) begin
      edge_mem[edge_total[AW-1:0]] <= '{from_v: in_data.edge_from,
                                        to_v:   in_data.edge_to,
                                        weight: in_data.edge_weight};
    end
    if (cmd.fetch) begin
      edge_q <= edge_mem[edge_idx[AW-1:0]];
    end
  end

  // Distance memory: one write port, two registered read ports. The reads are held
  // between commands so that a waiting result keeps its distance.
  always_ff @(posedge clk) begin
    if (cmd.init && src_ok) begin
      dist_mem[source_vertex[VW-1:0]] <= '0;
    end else if (cmd.relax && improve && !checking) begin
      dist_mem[v_idx] <= cand;
    end
    if (cmd.dread || cmd.out_rd) begin
      dist_a <= dist_mem[addr_a];
    end
    if (cmd.dread) begin
      dist_b <= dist_mem[v_idx];
    end
  end

  // Relaxation: exact sum, saturated to 32 bits, then compared.
  assign edge_ok = ({1'b0, edge_q.from_v} < nv) && ({1'b0, edge_q.to_v} < nv) &&
                   reached[u_idx];
  assign sum = $signed({dist_a[sssp_pkg::DIST_W-1], dist_a}) +
               (sssp_pkg::DIST_W+1)'(edge_q.weight);

  always_comb begin
    unique case (sum[sssp_pkg::DIST_W:sssp_pkg::DIST_W-1])
      2'b01:   cand = {1'b0, {(sssp_pkg::DIST_W-1){1'b1}}};
      2'b10:   cand = {1'b1, {(sssp_pkg::DIST_W-1){1'b0}}};
      default: cand = sum[sssp_pkg::DIST_W-1:0];
    endcase
  end

  assign improve = edge_ok && (!reached[v_idx] || (cand < $signed(dist_b)));

  always_ff @(posedge clk) begin
    if (rst) begin
      reached    <= '0;
      edge_total <= '0;
      edge_idx   <= '0;
      pass_cnt   <= '0;
      out_idx    <= '0;
      changed    <= 1'b0;
      checking   <= 1'b0;
      neg        <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_acc && (edge_total < EDGE_CAP)) begin
        edge_total <= edge_total + EW'(1);
      end
      if (cmd.init) begin
        reached  <= src_ok ? (NV_LIMIT'(1) << source_vertex[VW-1:0]) : '0;
        edge_idx <= '0;
        pass_cnt <= sssp_pkg::COUNT_W'(1);
        out_idx  <= '0;
        changed  <= 1'b0;
        checking <= (nv <= sssp_pkg::COUNT_W'(1));
        neg      <= 1'b0;
      end
      if (cmd.relax) begin
        edge_idx <= edge_idx + EW'(1);
        if (improve) begin
          changed <= 1'b1;
          if (!checking) begin
            reached[v_idx] <= 1'b1;
          end
        end
      end
      if (cmd.pass_end) begin
        edge_idx <= '0;
        changed  <= 1'b0;
        if (checking) begin
          neg <= changed;
        end else if (!changed || (pass_cnt + sssp_pkg::COUNT_W'(1) >= nv)) begin
          checking <= 1'b1;
        end else begin
          pass_cnt <= pass_cnt + sssp_pkg::COUNT_W'(1);
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
        out_idx   <= out_idx + sssp_pkg::COUNT_W'(1);
        if (sts.out_last) begin
          edge_total <= '0;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.vertex_id      <= out_idx[sssp_pkg::VERTEX_W-1:0];
      out_data.reachable      <= reached[o_idx];
      out_data.distance       <= reached[o_idx] ? $signed(dist_a) : '0;
      out_data.negative_cycle <= neg;
      out_data.last_vertex    <= sts.out_last;
    end
  end

  always_comb begin
    sts.start       = in_acc && in_data.last_edge;
    sts.src_ok      = src_ok;
    sts.edges_empty = (edge_total == '0);
    sts.edge_last   = ((edge_idx + EW'(1)) == edge_total);
    sts.checking    = checking;
    sts.out_free    = !out_valid || !out_stall;
    sts.out_last    = (out_idx == (nv - sssp_pkg::COUNT_W'(1)));
  end

endmodule

// File: src/single_source_shortest_path_engine.sv
// Single-source shortest path engine: edges load at one transfer per cycle while the engine
// waits for a graph; the last edge starts the run. A run seeds the source, then relaxes each
// stored edge in turn (fetch, distance read, relax) and closes each pass, for up to
// vertex_count-1 relaxation passes and one check pass, then reads and outputs each result.
// Synchronous reset clears the marks, counters and registers; no clearing sweep of the
// memories is needed, so the block is ready right after reset.
`timescale 1ns / 1ps

module single_source_shortest_path_engine #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_EDGES    = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  sssp_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output sssp_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [sssp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sssp_pkg::CFG_W-1:0]      cfg_data
);

  // The controller sequences the run; the datapath holds all storage and arithmetic.
  sssp_pkg::cmd_t cmd;
  sssp_pkg::sts_t sts;

  // Edges are taken only while the controller waits for a graph. During a run and while
  // results drain, the input channel is stalled.
  assign in_stall = !cmd.load_en;

  sssp_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // The datapath relaxes each edge in turn: fetch the edge, read both end-point
  // distances, then add, saturate, compare and write back. Results leave through an output
  // register, so one result can wait there while the next distance is read.
  sssp_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// File: verif/single_source_shortest_path_engine_tb.sv
// Self-checking testbench for the single-source shortest path engine.
// Drives edge lists and register writes, and predicts the per-vertex results in its own model.
// Depends on sssp_pkg and single_source_shortest_path_engine.
`timescale 1ns / 1ps

module single_source_shortest_path_engine_tb;

  // These match the default parameters of the engine.
  localparam int MAX_VERTICES = 32;
  localparam int MAX_EDGES    = 256;

  localparam int          RANDOM_LINKS  = 480;
  localparam int          BIG_GRAPH     = 4;       // this random graph overflows the edge list
  localparam int          SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam longint      DIST_HI       = 64'sd2147483647;
  localparam longint      DIST_LO       = -64'sd2147483648;

  // One row of the directed sequence. When reprogram is set, the registers are written
  // (with the engine idle) before the edge is offered. When typed is set, the edge closes a
  // graph and the result for typed_vertex is expected to carry the hand-worked values below.
  typedef struct packed {
    logic                               reprogram;
    logic [sssp_pkg::CFG_W-1:0]         source_val;
    logic [sssp_pkg::CFG_W-1:0]         count_val;
    sssp_pkg::in_t                      link;
    logic                               typed;
    logic [sssp_pkg::VERTEX_W-1:0]      typed_vertex;
    logic                               typed_reach;
    logic signed [sssp_pkg::DIST_W-1:0] typed_dist;
    logic                               typed_neg;
  } step_row_t;

  localparam int DIRECTED_COUNT = 17;

  localparam step_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // Straight after reset: source 0, all 32 vertices, a single edge.
    '{1'b0, 6'd0,  6'd0,  '{5'd0,  5'd1,  16'sd5,    1'b1}, 1'b1, 5'd1, 1'b1, 32'sd5,   1'b0},
    // A vertex count of zero runs as one vertex; the negative self-loop is a cycle.
    '{1'b1, 6'd0,  6'd0,  '{5'd0,  5'd0,  -16'sd1,   1'b1}, 1'b1, 5'd0, 1'b1, 32'sd0,   1'b1},
    // Count 63 saturates to 32; source 31 written with the spare data bit set.
    '{1'b1, 6'h3F, 6'h3F, '{5'd31, 5'd0,  16'sh7FFF, 1'b0}, 1'b0, 5'd0, 1'b0, 32'sd0,   1'b0},
    '{1'b0, 6'd0,  6'd0,  '{5'd0,  5'd1,  16'sh8000, 1'b0}, 1'b0, 5'd0, 1'b0, 32'sd0,   1'b0},
    '{1'b0, 6'd0,  6'd0,  '{5'd1,  5'd30, 16'sd0,    1'b1}, 1'b1, 5'd1, 1'b1, -32'sd1,  1'b0},
    // Source beyond the vertices in use: nothing is reachable.
    '{1'b1, 6'd10, 6'd4,  '{5'd10, 5'd2,  16'sd7,    1'b1}, 1'b1, 5'd2, 1'b0, 32'sd0,   1'b0},
    // Edges through a vertex outside those in use are ignored.
    '{1'b1, 6'd0,  6'd4,  '{5'd0,  5'd1,  16'sd3,    1'b0}, 1'b0, 5'd0, 1'b0, 32'sd0,   1'b0},
    '{1'b0, 6'd0,  6'd0,  '{5'd1,  5'd5,  16'sd1,    1'b0}, 1'b0, 5'd0, 1'b0, 32'sd0,   1'b0},
    '{1'b0, 6'd0,  6'd0,  '{5'd5,  5'd2,  16'sd1,    1'b0}, 1'b0, 5'd0, 1'b0, 32'sd0,   1'b0},
    '{1'b0, 6'd0,  6'd0,  '{5'd1,  5'd3,  -16'sd2,   1'b1}, 1'b1, 5'd3, 1'b1, 32'sd1,   1'b0},
    // A reachable negative cycle between vertices 1 and 2.
    '{1'b1, 6'd0,  6'd3,  '{5'd0,  5'd1,  16'sd1,    1'b0}, 1'b0, 5'd0, 1'b0, 32'sd0,   1'b0},
    '{1'b0, 6'd0,  6'd0,  '{5'd1,  5'd2,  -16'sd1,   1'b0}, 1'b0, 5'd0, 1'b0, 32'sd0,   1'b0},
    '{1'b0, 6'd0,  6'd0,  '{5'd2,  5'd1,  -16'sd1,   1'b1}, 1'b1, 5'd0, 1'b1, 32'sd0,   1'b1},
    // A chain loaded in reverse order needs every one of the vertex_count-1 passes.
    '{1'b1, 6'd4,  6'd5,  '{5'd1,  5'd0,  -16'sd3,   1'b0}, 1'b0, 5'd0, 1'b0, 32'sd0,   1'b0},
    '{1'b0, 6'd0,  6'd0,  '{5'd2,  5'd1,  -16'sd3,   1'b0}, 1'b0, 5'd0, 1'b0, 32'sd0,   1'b0},
    '{1'b0, 6'd0,  6'd0,  '{5'd3,  5'd2,  -16'sd3,   1'b0}, 1'b0, 5'd0, 1'b0, 32'sd0,   1'b0},
    '{1'b0, 6'd0,  6'd0,  '{5'd4,  5'd3,  -16'sd3,   1'b1}, 1'b1, 5'd0, 1'b1, -32'sd12, 1'b0}
  };

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_stall;
  sssp_pkg::in_t                  in_data;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  sssp_pkg::out_t                 out_data;
  logic                           cfg_we;
  logic [sssp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sssp_pkg::CFG_W-1:0]     cfg_data;

  // Predictor state: the edge list of the graph being loaded, the register copies and the
  // per-vertex working values of the current run.
  sssp_pkg::edge_t graph_edges[$];
  logic [4:0]      src_reg;
  logic [5:0]      count_reg;
  bit              reached [MAX_VERTICES];
  int              dist_of [MAX_VERTICES];
  int              run_width;
  sssp_pkg::out_t  awaited_vertices[$];

  int            failures    = 0;
  bit            calm        = 1'b0;   // suppresses idling on both sides for a stretch
  int unsigned   cycle_count = 0;

  single_source_shortest_path_engine i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // The vertex count register runs as at least one vertex and at most the full set.
  function automatic int used_vertices(logic [sssp_pkg::CFG_W-1:0] c);
    if (c == 0) return 1;
    if (c > MAX_VERTICES) return MAX_VERTICES;
    return int'(c);
  endfunction

  // One sweep over the stored edges in load order. With apply clear it only reports whether
  // any edge could still be relaxed, which is the negative cycle test.
  function automatic bit relax_pass(int nv, bit apply);
    bit                                   changed;
    int                                   u;
    int                                   v;
    int                                   cand;
    longint                               sum;
    logic signed [sssp_pkg::WEIGHT_W-1:0] w;
    changed = 1'b0;
    foreach (graph_edges[j]) begin
      u = int'(graph_edges[j].from_v);
      v = int'(graph_edges[j].to_v);
      if (u >= nv || v >= nv || !reached[u]) continue;
      w   = graph_edges[j].weight;
      sum = longint'(dist_of[u]) + longint'(w);
      // Sums are exact and then clamped to the 32-bit signed range.
      if (sum > DIST_HI) cand = int'(DIST_HI);
      else if (sum < DIST_LO) cand = int'(DIST_LO);
      else cand = int'(sum);
      if (!reached[v] || cand < dist_of[v]) begin
        changed = 1'b1;
        if (!apply) return 1'b1;
        dist_of[v] = cand;
        reached[v] = 1'b1;
      end
    end
    return changed;
  endfunction

  // Takes one transferred edge into the predictor. Edges past the capacity of the list are
  // dropped, but a last edge still starts the run on what was stored.
  function automatic void record_edge(sssp_pkg::in_t e);
    int             nv;
    bit             neg;
    sssp_pkg::out_t r;
    if (graph_edges.size() < MAX_EDGES)
      graph_edges.push_back('{from_v: e.edge_from, to_v: e.edge_to, weight: e.edge_weight});
    if (!e.last_edge) return;
    nv  = used_vertices(count_reg);
    neg = 1'b0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      reached[i] = 1'b0;
      dist_of[i] = 0;
    end
    if (src_reg < nv) begin
      reached[src_reg] = 1'b1;
      for (int p = 1; p < nv; p++) begin
        if (!relax_pass(nv, 1'b1)) break;
      end
      neg = relax_pass(nv, 1'b0);
    end
    for (int i = 0; i < nv; i++) begin
      r.vertex_id      = (sssp_pkg::VERTEX_W)'(i);
      r.reachable      = reached[i];
      r.distance       = reached[i] ? dist_of[i] : 32'sd0;
      r.negative_cycle = neg;
      r.last_vertex    = (i == nv - 1);
      awaited_vertices.push_back(r);
    end
    run_width = nv;
    graph_edges.delete();
  endfunction

  function automatic void check_field(string name, int vtx, longint want, longint got);
    if (want != got) begin
      failures++;
      $display("%0t: vertex %0d %s expected %0d, actual %0d", $time, vtx, name, want, got);
    end
  endfunction

  // Offers one edge, with an occasional gap beforehand, and holds it until the transfer.
  // The stall is read straight after the edge, so it is the value the engine presented.
  task automatic offer_edge(input sssp_pkg::in_t link);
    while (!calm && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= link;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    record_edge(link);
  endtask

  // Stops offering edges, waits for every predicted result and then lets the engine settle.
  task automatic await_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_vertices.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers on consecutive edges, keeping the write enable high between them.
  task automatic program_regs(input logic [sssp_pkg::CFG_W-1:0] src_val,
                              input logic [sssp_pkg::CFG_W-1:0] cnt_val);
    cfg_we    <= 1'b1;
    cfg_index <= sssp_pkg::REG_SOURCE_VERTEX;
    cfg_data  <= src_val;
    @(posedge clk);
    cfg_index <= sssp_pkg::REG_VERTEX_COUNT;
    cfg_data  <= cnt_val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    src_reg   = src_val[sssp_pkg::VERTEX_W-1:0];
    count_reg = cnt_val;
  endtask

  // Result side: every transfer is compared with the oldest predicted result, and the stall
  // is redrawn each cycle.
  always @(posedge clk) begin : result_check
    sssp_pkg::out_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (awaited_vertices.size() == 0) begin
          failures++;
          $display("%0t: unexpected result, vertex %0d distance %0d", $time,
                   out_data.vertex_id, out_data.distance);
        end else begin
          want = awaited_vertices.pop_front();
          check_field("vertex_id", want.vertex_id, want.vertex_id, out_data.vertex_id);
          check_field("reachable", want.vertex_id, want.reachable, out_data.reachable);
          check_field("distance", want.vertex_id, longint'(want.distance),
                      longint'(out_data.distance));
          check_field("negative_cycle", want.vertex_id, want.negative_cycle,
                      out_data.negative_cycle);
          check_field("last_vertex", want.vertex_id, want.last_vertex, out_data.last_vertex);
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 7);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("single_source_shortest_path_engine regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    step_row_t                            row;
    sssp_pkg::in_t                        link;
    sssp_pkg::out_t                       r;
    int                                   idx;
    int                                   nv;
    int                                   n_links;
    int                                   sent;
    int                                   graph;
    int                                   pick;
    logic [sssp_pkg::CFG_W-1:0]           cnt_val;
    logic [sssp_pkg::CFG_W-1:0]           src_val;
    logic signed [sssp_pkg::WEIGHT_W-1:0] w;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = sssp_pkg::REG_SOURCE_VERTEX;
    cfg_data  = '0;
    src_reg   = 5'd0;
    count_reg = 6'd32;
    run_width = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part: each row is predicted like any other edge, and where a row carries a
    // hand-worked value that value replaces the prediction for its vertex.
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.reprogram) begin
        await_idle();
        program_regs(row.source_val, row.count_val);
      end
      offer_edge(row.link);
      if (row.typed) begin
        idx              = awaited_vertices.size() - run_width + int'(row.typed_vertex);
        r                = awaited_vertices[idx];
        r.reachable      = row.typed_reach;
        r.distance       = row.typed_dist;
        r.negative_cycle = row.typed_neg;
        awaited_vertices[idx] = r;
      end
    end

    // Random part: whole graphs with random content. Most graphs use a handful of vertices
    // and edges so that runs stay short; a few use the full vertex set, and one graph
    // overflows the edge list so that its trailing edges are dropped, while its last edge
    // still starts the run.
    sent  = 0;
    graph = 0;
    while (sent < RANDOM_LINKS) begin
      calm = (graph >= 12 && graph < 24);
      if (graph == 0 || $urandom_range(0, 99) < 60) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) cnt_val = (sssp_pkg::CFG_W)'($urandom_range(2, 8));
        else if (pick < 80) cnt_val = (sssp_pkg::CFG_W)'($urandom_range(9, 32));
        else if (pick < 85) cnt_val = (sssp_pkg::CFG_W)'($urandom_range(0, 1));
        else if (pick < 92) cnt_val = 6'd32;
        else cnt_val = (sssp_pkg::CFG_W)'($urandom_range(33, 63));
        nv = used_vertices(cnt_val);
        // The source mostly lies among the vertices in use; the top data bit is don't-care.
        src_val = {1'($urandom_range(0, 1)),
                   ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, nv - 1))
                                                : 5'($urandom_range(0, 31))};
        await_idle();
        program_regs(src_val, cnt_val);
      end
      nv      = used_vertices(count_reg);
      n_links = (graph == BIG_GRAPH) ? MAX_EDGES + 4 : $urandom_range(1, 12);
      for (int k = 0; k < n_links; k++) begin
        // Each end point is drawn from all 32 vertex ids a tenth of the time, so it may lie outside those in use.
        link.edge_from = ($urandom_range(0, 99) < 90) ? 5'($urandom_range(0, nv - 1))
                                                      : 5'($urandom_range(0, 31));
        link.edge_to   = ($urandom_range(0, 99) < 90) ? 5'($urandom_range(0, nv - 1))
                                                      : 5'($urandom_range(0, 31));
        pick = $urandom_range(0, 99);
        if (pick < 55) w = 16'($urandom_range(0, 50));
        else if (pick < 80) w = 16'($urandom_range(0, 30)) - 16'd10;
        else if (pick < 95) w = 16'($urandom);
        else w = pick[0] ? 16'sh7FFF : 16'sh8000;
        link.edge_weight = w;
        link.last_edge   = (k == n_links - 1);
        offer_edge(link);
      end
      sent += n_links;
      graph++;
    end

    await_idle();
    if (failures == 0) begin
      $display("single_source_shortest_path_engine regression: pass");
    end else begin
      $display("single_source_shortest_path_engine regression: fail");
    end
    $finish;
  end

endmodule
